[src/assert_macros.svh]
// Assertion macros shared by the RTL of the control endpoint sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_AT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define ASSERT_DFLT(lbl, prop, msg) `ASSERT_AT(lbl, clk, rst_n, prop, msg)
`else
`define ASSERT_AT(lbl, clk_s, rst_s, prop, msg)
`define ASSERT_DFLT(lbl, prop, msg)
`endif
`endif

[src/ucep_pkg.sv]
// Types and constants of the USB control endpoint sequencer.
package ucep_pkg;

    typedef enum logic [1:0] {
        EV_BUS_RESET = 2'd0,
        EV_SETUP     = 2'd1,
        EV_POLL      = 2'd2,
        EV_IN_DONE   = 2'd3
    } ev_kind_t;

    typedef enum logic [2:0] {
        ACT_DATA          = 3'd0,
        ACT_ZLP           = 3'd1,
        ACT_SET_ADDRESS   = 3'd2,
        ACT_CONFIGURE     = 3'd3,
        ACT_REPORT        = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_SETUP      = 3'd0,
        ST_DATA_IN    = 3'd1,
        ST_DATA_IDLE  = 3'd2,
        ST_DATA_ZERO  = 3'd3,
        ST_STATUS_OUT = 3'd4,
        ST_STATUS_IN  = 3'd5
    } stage_t;

    localparam logic [1:0] SRC_DEVICE = 2'd0;
    localparam logic [1:0] SRC_CONFIG = 2'd1;
    localparam logic [1:0] SRC_HID    = 2'd2;

    localparam logic [1:0] DS_DEFAULT    = 2'd0;
    localparam logic [1:0] DS_ADDRESSED  = 2'd1;
    localparam logic [1:0] DS_CONFIGURED = 2'd2;

    localparam logic [6:0] SEL_STD_DEVICE    = 7'h00;
    localparam logic [6:0] SEL_STD_INTERFACE = 7'h01;
    localparam logic [6:0] SEL_CLASS_IFACE   = 7'h21;

    localparam logic [7:0] REQ_SET_ADDRESS = 8'h05;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'h09;
    localparam logic [7:0] REQ_SET_IDLE = 8'h0a;

    localparam logic [7:0] DT_DEVICE     = 8'h01;
    localparam logic [7:0] DT_CONFIG     = 8'h02;
    localparam logic [7:0] DT_HID_REPORT = 8'h22;

    localparam logic [2:0] CFG_EP0_MAX_PACKET   = 3'd0;
    localparam logic [2:0] CFG_MOUSE_ENDPOINT   = 3'd1;
    localparam logic [2:0] CFG_MOUSE_EP_TYPE    = 3'd2;
    localparam logic [2:0] CFG_MOUSE_MAX_PACKET = 3'd3;
    localparam logic [2:0] CFG_HID_REPORT_LEN   = 3'd4;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_length;
        logic [3:0]  done_ep;
    } evt_t;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] target_endpoint;
        logic [1:0] source;
        logic [7:0] offset;
        logic [9:0] length;
        logic [6:0] set_addr;
        logic [1:0] usb_state;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [6:0] ep0_max_packet;
        logic [3:0] mouse_endpoint;
        logic [9:0] mouse_max_packet;
        logic [7:0] hid_report_length;
    } cfg_t;

    typedef struct packed {
        res_t       res0;
        res_t       res1;
        logic [1:0] count;
    } eng_out_t;

endpackage

[src/ucep_ifs.sv]
// Handshake interfaces for the event, result and configuration channels.
interface ucep_evt_if import ucep_pkg::*; ();
    logic valid;
    logic ready;
    evt_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ucep_res_if import ucep_pkg::*; ();
    logic valid;
    logic ready;
    res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ucep_cfg_if ();
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [9:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[src/ucep_cfg_regs.sv]
// Configuration register file of the control endpoint sequencer.
module ucep_cfg_regs import ucep_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [2:0] wr_index,
    input  logic [9:0] wr_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;

    // The report endpoint type is accepted but affects no result, so it is not stored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ep0_max_packet    <= 7'd64;
            cfg_reg.mouse_endpoint    <= 4'd1;
            cfg_reg.mouse_max_packet  <= 10'd4;
            cfg_reg.hid_report_length <= 8'd52;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_EP0_MAX_PACKET:   cfg_reg.ep0_max_packet    <= wr_data[6:0];
                CFG_MOUSE_ENDPOINT:   cfg_reg.mouse_endpoint    <= wr_data[3:0];
                CFG_MOUSE_MAX_PACKET: cfg_reg.mouse_max_packet  <= wr_data;
                CFG_HID_REPORT_LEN:   cfg_reg.hid_report_length <= wr_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/ucep_engine.sv]
// Control transfer state and event decode; yields up to two results per event.
module ucep_engine import ucep_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  evt_t     evt,
    input  cfg_t     cfg,
    output eng_out_t eo
);

    stage_t     stage_reg, stage_next;
    logic [7:0] remain_reg, remain_next;
    logic [7:0] offset_reg, offset_next;
    logic [1:0] source_reg, source_next;
    logic [1:0] dstate_reg, dstate_next;

    logic [6:0] sel;
    logic [7:0] dtype;
    logic [7:0] max8;
    logic [7:0] chunk;
    logic       zlp_hit;
    logic       rpt_hit;
    res_t       r0, r1, rpt;
    logic [1:0] n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg  <= ST_SETUP;
            remain_reg <= '0;
            offset_reg <= '0;
            source_reg <= SRC_DEVICE;
            dstate_reg <= DS_DEFAULT;
        end
        else if (accept)
        begin
            stage_reg  <= stage_next;
            remain_reg <= remain_next;
            offset_reg <= offset_next;
            source_reg <= source_next;
            dstate_reg <= dstate_next;
        end
    end

    assign sel   = evt.request_type[6:0];
    assign dtype = evt.request_value[15:8];
    assign max8  = {1'b0, cfg.ep0_max_packet};
    assign chunk = (remain_reg < max8) ? remain_reg : max8;

    always_comb
    begin
        stage_next  = stage_reg;
        remain_next = remain_reg;
        offset_next = offset_reg;
        source_next = source_reg;
        dstate_next = dstate_reg;
        r0 = '0;
        r1 = '0;
        n  = 2'd0;
        zlp_hit = 1'b0;
        rpt_hit = 1'b0;
        rpt = '0;
        rpt.action          = ACT_REPORT;
        rpt.target_endpoint = cfg.mouse_endpoint;
        rpt.length          = cfg.mouse_max_packet;

        case (ev_kind_t'(evt.kind))
            EV_BUS_RESET:
            begin
                remain_next = '0;
                dstate_next = DS_DEFAULT;
                stage_next  = ST_SETUP;
                r0.action   = ACT_SET_ADDRESS;
                n = 2'd1;
            end
            EV_SETUP:
            begin
                if (sel == SEL_STD_DEVICE)
                begin
                    case (evt.request_code)
                        REQ_GET_DESCRIPTOR:
                        begin
                            if (dtype == DT_DEVICE || dtype == DT_CONFIG)
                            begin
                                source_next = (dtype == DT_DEVICE) ? SRC_DEVICE : SRC_CONFIG;
                                offset_next = '0;
                                remain_next = evt.request_length[7:0];
                                stage_next  = ST_DATA_IN;
                            end
                        end
                        REQ_SET_ADDRESS:
                        begin
                            r0.action   = ACT_SET_ADDRESS;
                            r0.set_addr = evt.request_value[6:0];
                            dstate_next = DS_ADDRESSED;
                            stage_next  = ST_STATUS_IN;
                            n = 2'd1;
                        end
                        REQ_SET_CONFIGURATION:
                        begin
                            r0.action          = ACT_CONFIGURE;
                            r0.target_endpoint = cfg.mouse_endpoint;
                            r0.length          = cfg.mouse_max_packet;
                            r1.action          = ACT_ZLP;
                            r1.target_endpoint = cfg.mouse_endpoint;
                            dstate_next = DS_CONFIGURED;
                            stage_next  = ST_STATUS_IN;
                            n = 2'd2;
                        end
                        default: ;
                    endcase
                end
                else if (sel == SEL_CLASS_IFACE)
                begin
                    if (evt.request_code == REQ_SET_IDLE)
                    begin
                        stage_next = ST_STATUS_IN;
                    end
                end
                else if (sel == SEL_STD_INTERFACE)
                begin
                    // Any request to the interface that names the report descriptor reads it.
                    if (dtype == DT_HID_REPORT)
                    begin
                        source_next = SRC_HID;
                        offset_next = '0;
                        remain_next = cfg.hid_report_length;
                        stage_next  = ST_DATA_IN;
                    end
                end
            end
            EV_POLL:
            begin
                case (stage_reg)
                    ST_DATA_IN:
                    begin
                        r0.action = ACT_DATA;
                        r0.source = source_reg;
                        r0.offset = offset_reg;
                        r0.length = {2'b00, chunk};
                        remain_next = remain_reg - chunk;
                        offset_next = offset_reg + chunk;
                        if (remain_reg == chunk)
                        begin
                            stage_next = (chunk == max8) ? ST_DATA_ZERO : ST_STATUS_OUT;
                        end
                        else
                        begin
                            stage_next = ST_DATA_IDLE;
                        end
                        n = 2'd1;
                    end
                    ST_STATUS_OUT:
                    begin
                        stage_next = ST_SETUP;
                    end
                    ST_STATUS_IN:
                    begin
                        r0.action  = ACT_ZLP;
                        stage_next = ST_SETUP;
                        n = 2'd1;
                    end
                    default: ;
                endcase
            end
            EV_IN_DONE:
            begin
                if (remain_reg != 8'd0)
                begin
                    stage_next = ST_DATA_IN;
                end
                else if (stage_reg == ST_DATA_ZERO)
                begin
                    zlp_hit    = 1'b1;
                    stage_next = ST_STATUS_OUT;
                end
                rpt_hit = (evt.done_ep == cfg.mouse_endpoint);
                if (zlp_hit)
                begin
                    r0.action = ACT_ZLP;
                    r1 = rpt;
                end
                else
                begin
                    r0 = rpt;
                end
                n = {1'b0, zlp_hit} + {1'b0, rpt_hit};
            end
            default: ;
        endcase

        r0.usb_state = dstate_next;
        r1.usb_state = dstate_next;
        r0.last = (n == 2'd1);
        r1.last = 1'b1;
    end

    assign eo.res0  = r0;
    assign eo.res1  = r1;
    assign eo.count = n;

endmodule

[src/ucep_out_fifo.sv]
// Four-entry result queue that takes up to two results per cycle and gives one.
module ucep_out_fifo import ucep_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  eng_out_t   eo,
    input  logic       pop,
    output logic       space2,
    output logic       not_empty,
    output res_t       head,
    output logic [2:0] fill
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    res_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0]    count_reg, count_next;
    logic [1:0]    n_push;
    logic [PW-1:0] wr_ptr_p1;

    assign n_push     = push ? eo.count : 2'd0;
    assign wr_ptr_p1  = wr_ptr_reg + PW'(1);
    assign count_next = count_reg + {1'b0, n_push} - {2'b00, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PW'(n_push);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= eo.res0;
        end
        if (n_push == 2'd2)
        begin
            mem_reg[wr_ptr_p1] <= eo.res1;
        end
    end

    assign space2    = (count_reg <= 3'(QUEUE_DEPTH - 2));
    assign not_empty = (count_reg != 3'd0);
    assign head      = mem_reg[rd_ptr_reg];
    assign fill      = count_reg;

endmodule

[src/usb_control_endpoint_sequencer_core.sv]
// Top level of the USB endpoint-zero control sequencer with a HID report endpoint.
//
//  Channel | Direction | Transaction carries
//  --------+-----------+-----------------------------------------------------
//  evt     | in        | one bus event: reset, setup packet, poll tick, IN done
//  res     | out       | one result: packet, address, endpoint setup, report
//  cfg     | in        | one register write: index and data
//
// An event is decoded and the sequencer state updated in the cycle it is taken,
// and its zero to two results enter a four-entry queue; one event per cycle while
// evt.ready is high. Results leave the queue one per cycle while res.ready is high.
// evt.ready drops while fewer than two queue slots are free; cfg is always ready.
// Reset is asynchronous and needs no clearing pass.
module usb_control_endpoint_sequencer_core import ucep_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    ucep_evt_if.sink     evt,
    ucep_res_if.source   res,
    ucep_cfg_if.sink     cfg
);

`include "assert_macros.svh"

    cfg_t       cfg_q;
    eng_out_t   eo;
    logic       evt_accept;
    logic       res_pop;
    logic       space2;
    logic       not_empty;
    res_t       head;
    logic [2:0] fill;

    assign cfg.ready  = 1'b1;
    assign evt.ready  = space2;
    assign evt_accept = evt.valid && space2;
    assign res_pop    = not_empty && res.ready;
    assign res.valid  = not_empty;
    assign res.data   = head;

    ucep_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_q)
    );

    ucep_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (evt_accept),
        .evt    (evt.data),
        .cfg    (cfg_q),
        .eo     (eo)
    );

    ucep_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (evt_accept),
        .eo        (eo),
        .pop       (res_pop),
        .space2    (space2),
        .not_empty (not_empty),
        .head      (head),
        .fill      (fill)
    );

    `ASSERT_DFLT(a_fill_bound, fill <= 3'(QUEUE_DEPTH), "result queue overfilled")
    `ASSERT_DFLT(a_fill_track, evt_accept && !res_pop |=> fill == $past(fill) + 3'($past(eo.count)), "queue fill does not match results pushed")
    `ASSERT_DFLT(a_cfg_not_last, res.valid && res.data.action == ACT_CONFIGURE |-> !res.data.last, "configure result marked as final")

endmodule

[tb/sv/usb_control_endpoint_sequencer_core_tb.sv]
// Self-checking testbench for the USB endpoint-zero control sequencer core.
module usb_control_endpoint_sequencer_core_tb;
    import ucep_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_AT       = 150;
    localparam int HOLD_CYCLES   = 80;

    // Requests that the sequencer does not decode.
    localparam logic [6:0] SEL_VENDOR_DEVICE = 7'h40;
    localparam logic [7:0] REQ_GET_STATUS    = 8'h00;
    localparam logic [7:0] DT_STRING         = 8'h03;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    ucep_evt_if evt_ch ();
    ucep_res_if res_ch ();
    ucep_cfg_if cfg_ch ();

    usb_control_endpoint_sequencer_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // Register copies.
    logic [6:0] ep0_mps    = 7'd64;
    logic [3:0] mouse_ep   = 4'd1;
    logic [1:0] mouse_type = 2'd3;
    logic [9:0] mouse_mps  = 10'd4;
    logic [7:0] hid_len    = 8'd52;

    // Sequencer state as predicted.
    stage_t     seq_stage     = ST_SETUP;
    logic [7:0] left_bytes    = '0;
    logic [7:0] next_offset   = '0;
    logic [1:0] cur_source    = SRC_DEVICE;
    logic [1:0] dev_st        = DS_DEFAULT;
    logic [7:0] config_number = '0;

    evt_t pending_events[$];
    res_t awaited_results[$];

    bit calm = 1'b0;
    int gap_left = 0;
    int hold_left = 0;
    bit held_once = 1'b0;
    int events_taken = 0;
    int results_seen = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int phase_items = 0;

    function automatic res_t make_res(action_t act, logic [3:0] ep, logic [1:0] src,
                                      logic [7:0] off, logic [9:0] len, logic [6:0] addr);
        res_t r;
        r.action          = act;
        r.target_endpoint = ep;
        r.source          = src;
        r.offset          = off;
        r.length          = len;
        r.set_addr        = addr;
        r.usb_state       = '0;
        r.last            = 1'b0;
        return r;
    endfunction

    // Advances the predicted sequencer by one event and queues the results it causes.
    function automatic void sequence_event(evt_t e);
        res_t outs[2];
        int n;
        logic [6:0] sel;
        logic [7:0] dtype;
        logic [7:0] chunk;
        n = 0;
        sel = e.request_type[6:0];
        dtype = e.request_value[15:8];
        case (ev_kind_t'(e.kind))
            EV_BUS_RESET:
            begin
                left_bytes = '0;
                config_number = '0;
                dev_st = DS_DEFAULT;
                seq_stage = ST_SETUP;
                outs[n] = make_res(ACT_SET_ADDRESS, 4'd0, 2'd0, 8'd0, 10'd0, 7'd0);
                n = n + 1;
            end
            EV_SETUP:
            begin
                if (sel == SEL_STD_DEVICE)
                begin
                    if (e.request_code == REQ_GET_DESCRIPTOR)
                    begin
                        if (dtype == DT_DEVICE || dtype == DT_CONFIG)
                        begin
                            cur_source = (dtype == DT_DEVICE) ? SRC_DEVICE : SRC_CONFIG;
                            next_offset = '0;
                            left_bytes = e.request_length[7:0];
                            seq_stage = ST_DATA_IN;
                        end
                    end
                    else if (e.request_code == REQ_SET_ADDRESS)
                    begin
                        outs[n] = make_res(ACT_SET_ADDRESS, 4'd0, 2'd0, 8'd0, 10'd0,
                                           e.request_value[6:0]);
                        n = n + 1;
                        dev_st = DS_ADDRESSED;
                        seq_stage = ST_STATUS_IN;
                    end
                    else if (e.request_code == REQ_SET_CONFIGURATION)
                    begin
                        config_number = e.request_value[7:0];
                        outs[0] = make_res(ACT_CONFIGURE, mouse_ep, 2'd0, 8'd0, mouse_mps, 7'd0);
                        outs[1] = make_res(ACT_ZLP, mouse_ep, 2'd0, 8'd0, 10'd0, 7'd0);
                        n = 2;
                        dev_st = DS_CONFIGURED;
                        seq_stage = ST_STATUS_IN;
                    end
                end
                else if (sel == SEL_CLASS_IFACE)
                begin
                    if (e.request_code == REQ_SET_IDLE)
                        seq_stage = ST_STATUS_IN;
                end
                else if (sel == SEL_STD_INTERFACE)
                begin
                    // Any request code reads the report descriptor here.
                    if (dtype == DT_HID_REPORT)
                    begin
                        cur_source = SRC_HID;
                        next_offset = '0;
                        left_bytes = hid_len;
                        seq_stage = ST_DATA_IN;
                    end
                end
            end
            EV_POLL:
            begin
                case (seq_stage)
                    ST_DATA_IN:
                    begin
                        chunk = (left_bytes < {1'b0, ep0_mps}) ? left_bytes : {1'b0, ep0_mps};
                        outs[n] = make_res(ACT_DATA, 4'd0, cur_source, next_offset,
                                           {2'b00, chunk}, 7'd0);
                        n = n + 1;
                        left_bytes = left_bytes - chunk;
                        next_offset = next_offset + chunk;
                        seq_stage = ST_DATA_IDLE;
                        if (left_bytes == 8'd0)
                            seq_stage = (chunk == {1'b0, ep0_mps}) ? ST_DATA_ZERO : ST_STATUS_OUT;
                    end
                    ST_STATUS_OUT:
                        seq_stage = ST_SETUP;
                    ST_STATUS_IN:
                    begin
                        outs[n] = make_res(ACT_ZLP, 4'd0, 2'd0, 8'd0, 10'd0, 7'd0);
                        n = n + 1;
                        seq_stage = ST_SETUP;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                if (left_bytes != 8'd0)
                    seq_stage = ST_DATA_IN;
                else if (seq_stage == ST_DATA_ZERO)
                begin
                    outs[n] = make_res(ACT_ZLP, 4'd0, 2'd0, 8'd0, 10'd0, 7'd0);
                    n = n + 1;
                    seq_stage = ST_STATUS_OUT;
                end
                if (e.done_ep == mouse_ep)
                begin
                    outs[n] = make_res(ACT_REPORT, mouse_ep, 2'd0, 8'd0, mouse_mps, 7'd0);
                    n = n + 1;
                end
            end
        endcase
        for (int k = 0; k < n; k++)
        begin
            outs[k].usb_state = dev_st;
            outs[k].last = (k == n - 1);
            awaited_results.push_back(outs[k]);
        end
    endfunction

    function automatic string show(res_t r);
        return $sformatf("act=%0d ep=%0d src=%0d off=%0d len=%0d addr=%0d state=%0d last=%0d",
                         r.action, r.target_endpoint, r.source, r.offset, r.length,
                         r.set_addr, r.usb_state, r.last);
    endfunction

    function automatic void flag_error(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    function automatic void check_result(res_t got);
        res_t want;
        results_seen++;
        if (awaited_results.size() == 0)
        begin
            flag_error($sformatf("result %0d unexpected: %s", results_seen, show(got)));
            return;
        end
        want = awaited_results.pop_front();
        if (got.action !== want.action || got.target_endpoint !== want.target_endpoint ||
            got.source !== want.source || got.offset !== want.offset ||
            got.length !== want.length || got.set_addr !== want.set_addr ||
            got.usb_state !== want.usb_state || got.last !== want.last)
            flag_error($sformatf("result %0d expected %s, got %s",
                                 results_seen, show(want), show(got)));
    endfunction

    // Monitor: predict on each event transaction, then check each result transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (evt_ch.valid && evt_ch.ready)
            begin
                sequence_event(evt_ch.data);
                events_taken <= events_taken + 1;
            end
            if (res_ch.valid && res_ch.ready)
                check_result(res_ch.data);
        end
    end

    // Driver: a new event is offered only once the previous one has gone.
    always @(posedge clk)
    begin
        if (rst_n && (!evt_ch.valid || evt_ch.ready))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                evt_ch.valid <= 1'b0;
            end
            else if (!calm && pending_events.size() != 0 && $urandom_range(0, 9) == 0)
            begin
                gap_left = $urandom_range(1, 5) - 1;
                evt_ch.valid <= 1'b0;
            end
            else if (pending_events.size() != 0)
            begin
                evt_ch.data <= pending_events.pop_front();
                evt_ch.valid <= 1'b1;
            end
            else
                evt_ch.valid <= 1'b0;
        end
    end

    // Result receiver, with one long hold-off so that the event input backs up.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!held_once && events_taken >= HOLD_AT)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                hold_left = $urandom_range(1, 5) - 1;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic evt_t noise_event();
        logic [63:0] r;
        evt_t e;
        r = {$urandom, $urandom};
        e = r[$bits(evt_t)-1:0];
        return e;
    endfunction

    function automatic evt_t bare_event(ev_kind_t k, logic [3:0] ep);
        evt_t e;
        e = noise_event();
        e.kind = k;
        e.done_ep = ep;
        return e;
    endfunction

    function automatic evt_t setup_event(logic [7:0] rtype, logic [7:0] code,
                                         logic [15:0] value, logic [15:0] len);
        evt_t e;
        e = noise_event();
        e.kind = EV_SETUP;
        e.request_type = rtype;
        e.request_code = code;
        e.request_value = value;
        e.request_length = len;
        return e;
    endfunction

    function automatic void add_item(evt_t e);
        pending_events.push_back(e);
        phase_items++;
    endfunction

    function automatic logic [3:0] done_endpoint();
        return ($urandom_range(0, 1) == 0) ? mouse_ep : 4'($urandom);
    endfunction

    // Polls and completions enough to drain a read of len bytes, with spare idle polls.
    function automatic void queue_data_stage(int len);
        int rounds;
        rounds = (ep0_mps == 7'd0) ? $urandom_range(1, 4) : len / ep0_mps + 1;
        if (rounds > 40)
            rounds = 40;
        for (int r = 0; r <= rounds; r++)
        begin
            add_item(bare_event(EV_POLL, 4'($urandom)));
            if ($urandom_range(0, 3) == 0)
                add_item(bare_event(EV_POLL, 4'($urandom)));
            add_item(bare_event(EV_IN_DONE, done_endpoint()));
        end
        add_item(bare_event(EV_POLL, 4'($urandom)));
    endfunction

    function automatic void queue_transfer();
        int len;
        logic dir;
        logic [7:0] dtype;
        dir = 1'($urandom);
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4:
            begin
                dtype = ($urandom_range(0, 1) == 0) ? DT_DEVICE : DT_CONFIG;
                case ($urandom_range(0, 3))
                    0: len = (ep0_mps * $urandom_range(1, 3)) % 256;
                    1: len = $urandom_range(0, 255);
                    default: len = $urandom_range(0, 40);
                endcase
                add_item(setup_event({dir, SEL_STD_DEVICE}, REQ_GET_DESCRIPTOR,
                                     {dtype, 8'($urandom)}, {8'($urandom), 8'(len)}));
                queue_data_stage(len);
            end
            5, 6:
            begin
                add_item(setup_event({dir, SEL_STD_INTERFACE},
                                     ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                 : REQ_GET_DESCRIPTOR,
                                     {DT_HID_REPORT, 8'($urandom)}, 16'($urandom)));
                queue_data_stage(hid_len);
            end
            7:
            begin
                add_item(setup_event({dir, SEL_STD_DEVICE}, REQ_SET_ADDRESS,
                                     16'($urandom), 16'($urandom)));
                add_item(bare_event(EV_POLL, 4'($urandom)));
            end
            8:
            begin
                add_item(setup_event({dir, SEL_STD_DEVICE}, REQ_SET_CONFIGURATION,
                                     16'($urandom), 16'($urandom)));
                add_item(bare_event(EV_POLL, 4'($urandom)));
            end
            9:
            begin
                add_item(setup_event({dir, SEL_CLASS_IFACE}, REQ_SET_IDLE,
                                     16'($urandom), 16'($urandom)));
                add_item(bare_event(EV_POLL, 4'($urandom)));
            end
            10:
                add_item(bare_event(EV_BUS_RESET, 4'($urandom)));
            11:
                add_item(bare_event(EV_IN_DONE, mouse_ep));
            12, 13:
                add_item(noise_event());
            14:
            begin
                // A read cut short by a bus reset or a fresh request.
                add_item(setup_event({dir, SEL_STD_DEVICE}, REQ_GET_DESCRIPTOR,
                                     {DT_CONFIG, 8'($urandom)}, 16'($urandom)));
                add_item(bare_event(EV_POLL, 4'($urandom)));
                if ($urandom_range(0, 1) == 0)
                    add_item(bare_event(EV_BUS_RESET, 4'($urandom)));
                else
                    add_item(setup_event({dir, SEL_STD_DEVICE}, REQ_SET_ADDRESS,
                                         16'($urandom), 16'($urandom)));
                add_item(bare_event(EV_POLL, 4'($urandom)));
            end
            default:
                add_item(setup_event(8'($urandom), 8'($urandom),
                                     16'($urandom), 16'($urandom)));
        endcase
    endfunction

    function automatic void apply_register(logic [2:0] idx, logic [9:0] v);
        case (idx)
            CFG_EP0_MAX_PACKET:   ep0_mps = v[6:0];
            CFG_MOUSE_ENDPOINT:   mouse_ep = v[3:0];
            CFG_MOUSE_EP_TYPE:    mouse_type = v[1:0];
            CFG_MOUSE_MAX_PACKET: mouse_mps = v;
            CFG_HID_REPORT_LEN:   hid_len = v[7:0];
            default:
            begin
            end
        endcase
    endfunction

    // Called at a rising edge with the block idle; leaves at a rising edge.
    task automatic program_registers(logic [6:0] mps, logic [3:0] ep, logic [1:0] ty,
                                     logic [9:0] mmps, logic [7:0] hid);
        logic [2:0] idx [5];
        logic [9:0] vals [5];
        idx = '{CFG_EP0_MAX_PACKET, CFG_MOUSE_ENDPOINT, CFG_MOUSE_EP_TYPE,
                CFG_MOUSE_MAX_PACKET, CFG_HID_REPORT_LEN};
        vals = '{{3'b000, mps}, {6'b0, ep}, {8'b0, ty}, mmps, {2'b00, hid}};
        for (int i = 0; i < 5; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ch.ready);
            apply_register(idx[i], vals[i]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic settle();
        do
            @(posedge clk);
        while (pending_events.size() != 0 || evt_ch.valid || awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(int count);
        phase_items = 0;
        while (phase_items < count)
            queue_transfer();
        settle();
    endtask

    initial
    begin
        evt_ch.valid = 1'b0;
        evt_ch.data = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_registers(7'd64, 4'd1, 2'd3, 10'd4, 8'd52);

        // Directed: every decoded request, the idle stages and the odd corners.
        add_item(bare_event(EV_BUS_RESET, 4'd0));
        add_item(setup_event({1'b1, SEL_STD_DEVICE}, REQ_GET_DESCRIPTOR,
                             {DT_DEVICE, 8'h00}, 16'hff12));
        add_item(bare_event(EV_POLL, 4'd0));
        add_item(bare_event(EV_IN_DONE, mouse_ep));
        add_item(bare_event(EV_POLL, 4'd0));
        // Exact multiple of the packet size, so a zero-length packet follows.
        add_item(setup_event({1'b1, SEL_STD_DEVICE}, REQ_GET_DESCRIPTOR,
                             {DT_CONFIG, 8'hff}, 16'h0080));
        add_item(bare_event(EV_POLL, 4'd0));
        add_item(bare_event(EV_POLL, 4'd0));
        add_item(bare_event(EV_IN_DONE, 4'd15));
        add_item(bare_event(EV_POLL, 4'd0));
        add_item(bare_event(EV_IN_DONE, mouse_ep));
        add_item(bare_event(EV_POLL, 4'd0));
        add_item(setup_event({1'b1, SEL_STD_INTERFACE}, REQ_GET_DESCRIPTOR,
                             {DT_HID_REPORT, 8'h00}, 16'h0000));
        add_item(bare_event(EV_POLL, 4'd0));
        add_item(bare_event(EV_POLL, 4'd0));
        add_item(setup_event({1'b0, SEL_STD_DEVICE}, REQ_SET_ADDRESS, 16'hffff, 16'hffff));
        add_item(bare_event(EV_POLL, 4'd0));
        add_item(setup_event({1'b0, SEL_STD_DEVICE}, REQ_SET_CONFIGURATION,
                             16'h00ab, 16'h0000));
        add_item(bare_event(EV_POLL, 4'd0));
        add_item(setup_event({1'b1, SEL_CLASS_IFACE}, REQ_SET_IDLE, 16'h0000, 16'h0000));
        add_item(bare_event(EV_POLL, 4'd0));
        add_item(setup_event({1'b0, SEL_VENDOR_DEVICE}, REQ_GET_STATUS, 16'h0000, 16'h0000));
        add_item(setup_event({1'b0, SEL_STD_DEVICE}, REQ_GET_DESCRIPTOR,
                             {DT_STRING, 8'h00}, 16'h0040));
        // A read of no bytes still sends one empty data packet.
        add_item(setup_event({1'b0, SEL_STD_DEVICE}, REQ_GET_DESCRIPTOR,
                             {DT_DEVICE, 8'h00}, 16'hff00));
        add_item(bare_event(EV_POLL, 4'd0));
        add_item(bare_event(EV_POLL, 4'd0));
        add_item(bare_event(EV_IN_DONE, 4'd0));
        settle();
        run_random(80);

        program_registers(7'd8, 4'd15, 2'd0, 10'd1023, 8'd255);
        run_random(85);

        // Zero packet size: reads never drain until a bus reset.
        program_registers(7'd0, 4'd0, 2'd2, 10'd0, 8'd0);
        run_random(85);

        program_registers(7'd127, 4'd7, 2'd1, 10'd512, 8'd64);
        run_random(85);

        program_registers(7'($urandom_range(8, 64)), 4'($urandom_range(1, 15)),
                          2'($urandom), 10'($urandom), 8'($urandom));
        calm = 1'b1;
        run_random(80);

        if (mismatches == 0 && awaited_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
